// ===== rtl/spq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// shared widths, operation and status codes, and the controller/datapath
// command and status bundles of the sorted priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int SPQ_DEPTH    = 64;
  localparam int SPQ_TAG_BITS = 16;

  localparam int WEIGHT_W    = 31;
  localparam int TAG_FIELD_W = 16;
  localparam int OCC_W       = 7;
  localparam int STATUS_W    = 2;

  typedef logic [STATUS_W-1:0] status_t;

  localparam logic    KIND_PUSH  = 1'b0;
  localparam logic    KIND_POP   = 1'b1;

  localparam status_t ST_PUSHED  = 2'd0;
  localparam status_t ST_FULL    = 2'd1;
  localparam status_t ST_POPPED  = 2'd2;
  localparam status_t ST_EMPTY   = 2'd3;

  // commands from controller to datapath
  typedef struct packed {
    logic    latch_in;    // capture pushed weight and tag
    logic    init_push;   // slot pointer to tail, slot index to count
    logic    rd_prev;     // read the entry just below the slot pointer
    logic    rd_head;     // read the head entry
    logic    wr_shift;    // move the entry read last up into the slot
    logic    wr_new;      // write the new entry into the slot
    logic    pop_commit;  // advance head, drop count
    logic    load_out;    // load the result register
    status_t out_status;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic in_pop;   // input item is a pop
    logic full;
    logic empty;
    logic j_zero;   // insertion slot reached the head
    logic less;     // new weight is below the entry read last
  } sts_t;

endpackage

// ===== rtl/spq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ctrl
// sequencer of the sorted priority queue: input and output handshakes and
// the read/compare/shift steps of an insertion
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  spq_pkg::sts_t sts,
  output spq_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_PUSH_RD  = 3'd1;
  localparam logic [2:0] S_PUSH_CMP = 3'd2;
  localparam logic [2:0] S_POP      = 3'd3;
  localparam logic [2:0] S_FIN      = 3'd4;

  logic [2:0]       state_r, state_nxt;
  spq_pkg::status_t st_r, st_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_busy;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_busy  = out_valid_r && out_stall;

  always_comb begin
    state_nxt      = state_r;
    st_nxt         = st_r;
    cmd            = '0;
    cmd.out_status = st_r;
    out_valid_nxt  = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          if (sts.in_pop) begin
            if (sts.empty) begin
              st_nxt    = spq_pkg::ST_EMPTY;
              state_nxt = S_FIN;
            end else begin
              st_nxt    = spq_pkg::ST_POPPED;
              state_nxt = S_POP;
            end
          end else begin
            if (sts.full) begin
              st_nxt    = spq_pkg::ST_FULL;
              state_nxt = S_FIN;
            end else begin
              st_nxt        = spq_pkg::ST_PUSHED;
              cmd.init_push = 1'b1;
              state_nxt     = S_PUSH_RD;
            end
          end
        end
      end
      S_PUSH_RD: begin
        if (sts.j_zero) begin
          cmd.wr_new = 1'b1;
          state_nxt  = S_FIN;
        end else begin
          cmd.rd_prev = 1'b1;
          state_nxt   = S_PUSH_CMP;
        end
      end
      S_PUSH_CMP: begin
        if (sts.less) begin
          cmd.wr_shift = 1'b1;
          state_nxt    = S_PUSH_RD;
        end else begin
          cmd.wr_new = 1'b1;
          state_nxt  = S_FIN;
        end
      end
      S_POP: begin
        cmd.rd_head    = 1'b1;
        cmd.pop_commit = 1'b1;
        state_nxt      = S_FIN;
      end
      S_FIN: begin
        // hold until the previous result has been taken
        if (!out_busy) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      st_r        <= spq_pkg::ST_PUSHED;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !out_busy)
    else $error("result register overwritten while a transfer is pending");

  a_cmp_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUSH_CMP) |-> ($past(state_r) == S_PUSH_RD))
    else $error("compare step entered without a read");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) |-> (st_r == spq_pkg::ST_POPPED))
    else $error("pop step with wrong status");

endmodule

// ===== rtl/spq_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_dp
// datapath of the sorted priority queue: ring memory of sorted entries,
// head/tail pointers, count, insertion slot and the result register
// ----------------------------------------------------------------------------
module spq_dp #(
  parameter int DEPTH    = spq_pkg::SPQ_DEPTH,
  parameter int TAG_BITS = spq_pkg::SPQ_TAG_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_kind,
  input  logic [spq_pkg::WEIGHT_W-1:0]        in_entry_weight,
  input  logic [spq_pkg::TAG_FIELD_W-1:0]     in_entry_tag,
  input  spq_pkg::cmd_t                       cmd,
  output spq_pkg::sts_t                       sts,
  output spq_pkg::status_t                    out_status,
  output logic [spq_pkg::WEIGHT_W-1:0]        out_popped_weight,
  output logic [spq_pkg::TAG_FIELD_W-1:0]     out_popped_tag,
  output logic [spq_pkg::OCC_W-1:0]           out_occupancy,
  output logic                                out_is_empty
);

  localparam int PW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int TW    = (TAG_BITS < spq_pkg::TAG_FIELD_W) ? TAG_BITS : spq_pkg::TAG_FIELD_W;
  localparam int WW    = spq_pkg::WEIGHT_W;

  localparam logic [PW-1:0]    PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  // physical storage, kept sorted from head around the ring
  logic [WW-1:0] w_mem [DEPTH];
  logic [TW-1:0] t_mem [DEPTH];

  logic [WW-1:0]    op_w_r;
  logic [TW-1:0]    op_t_r;
  logic [WW-1:0]    rd_w_r;
  logic [TW-1:0]    rd_t_r;
  logic [PW-1:0]    hd_r, hd_nxt;
  logic [PW-1:0]    tl_r, tl_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0]    p_r;
  logic [CNT_W-1:0] j_r;
  logic [PW-1:0]    p_prev, hd_inc, tl_inc;

  logic             wr_en;
  logic [WW-1:0]    wr_w;
  logic [TW-1:0]    wr_t;
  logic             rd_en;
  logic [PW-1:0]    rd_addr;

  spq_pkg::status_t out_status_r;
  logic [WW-1:0]    out_w_r;
  logic [TW-1:0]    out_t_r;
  logic [CNT_W-1:0] out_cnt_r;

  assign p_prev = (p_r == '0) ? PTR_LAST : (p_r - PW'(1));
  assign hd_inc = (hd_r == PTR_LAST) ? '0 : (hd_r + PW'(1));
  assign tl_inc = (tl_r == PTR_LAST) ? '0 : (tl_r + PW'(1));

  assign sts.in_pop = (in_kind == spq_pkg::KIND_POP);
  assign sts.full   = (cnt_r == CNT_FULL);
  assign sts.empty  = (cnt_r == '0);
  assign sts.j_zero = (j_r == '0);
  assign sts.less   = (op_w_r < rd_w_r);

  assign wr_en   = cmd.wr_shift || cmd.wr_new;
  assign wr_w    = cmd.wr_shift ? rd_w_r : op_w_r;
  assign wr_t    = cmd.wr_shift ? rd_t_r : op_t_r;
  assign rd_en   = cmd.rd_prev || cmd.rd_head;
  assign rd_addr = cmd.rd_head ? hd_r : p_prev;

  always_comb begin
    hd_nxt  = hd_r;
    tl_nxt  = tl_r;
    cnt_nxt = cnt_r;
    if (cmd.wr_new) begin
      tl_nxt  = tl_inc;
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (cmd.pop_commit) begin
      hd_nxt  = hd_inc;
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      w_mem[p_r] <= wr_w;
      t_mem[p_r] <= wr_t;
    end
    if (rd_en) begin
      rd_w_r <= w_mem[rd_addr];
      rd_t_r <= t_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hd_r  <= '0;
      tl_r  <= '0;
      cnt_r <= '0;
    end else begin
      hd_r  <= hd_nxt;
      tl_r  <= tl_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_w_r <= in_entry_weight;
      op_t_r <= in_entry_tag[TW-1:0];
    end
    if (cmd.init_push) begin
      p_r <= tl_r;
      j_r <= cnt_r;
    end else if (cmd.wr_shift) begin
      p_r <= p_prev;
      j_r <= j_r - CNT_W'(1);
    end
    if (cmd.load_out) begin
      out_status_r <= cmd.out_status;
      out_cnt_r    <= cnt_r;
      if (cmd.out_status == spq_pkg::ST_POPPED) begin
        out_w_r <= rd_w_r;
        out_t_r <= rd_t_r;
      end else begin
        out_w_r <= '0;
        out_t_r <= '0;
      end
    end
  end

  assign out_status        = out_status_r;
  assign out_popped_weight = out_w_r;
  assign out_popped_tag    = spq_pkg::TAG_FIELD_W'(out_t_r);
  assign out_occupancy     = spq_pkg::OCC_W'(out_cnt_r);
  assign out_is_empty      = (out_cnt_r == '0);

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("entry count above depth");

  a_ring_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0 || cnt_r == CNT_FULL) |-> (hd_r == tl_r))
    else $error("head and tail pointers disagree with count");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_new |=> (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("insert did not raise the count");

endmodule

// ===== rtl/sorted_priority_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue
// min-priority queue of weight/tag entries kept sorted by ascending weight;
// equal weights leave in arrival order
// ----------------------------------------------------------------------------
//  channel  ports                                         direction
//  in       in_valid in_stall in_kind in_entry_weight     sink
//           in_entry_tag
//  out      out_valid out_stall out_status                source
//           out_popped_weight out_popped_tag out_occupancy out_is_empty
//
//  a pop reads the head; a dropped push or empty pop goes straight to finish;
//  a push moves each greater entry up, then writes the new entry into the slot;
//  each move is a memory read then a write; the ring means a pop moves no data
//  reset is synchronous, active low, and empties the queue at once
//  one result can wait in the output register while the next item is taken;
//  a further result holds in the finish step until out_stall drops
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
  parameter int DEPTH    = spq_pkg::SPQ_DEPTH,
  parameter int TAG_BITS = spq_pkg::SPQ_TAG_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_kind,
  input  logic [spq_pkg::WEIGHT_W-1:0]    in_entry_weight,
  input  logic [spq_pkg::TAG_FIELD_W-1:0] in_entry_tag,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [spq_pkg::STATUS_W-1:0]    out_status,
  output logic [spq_pkg::WEIGHT_W-1:0]    out_popped_weight,
  output logic [spq_pkg::TAG_FIELD_W-1:0] out_popped_tag,
  output logic [spq_pkg::OCC_W-1:0]       out_occupancy,
  output logic                            out_is_empty
);

  spq_pkg::cmd_t cmd;
  spq_pkg::sts_t sts;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  spq_dp #(
    .DEPTH    (DEPTH),
    .TAG_BITS (TAG_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_kind           (in_kind),
    .in_entry_weight   (in_entry_weight),
    .in_entry_tag      (in_entry_tag),
    .cmd               (cmd),
    .sts               (sts),
    .out_status        (out_status),
    .out_popped_weight (out_popped_weight),
    .out_popped_tag    (out_popped_tag),
    .out_occupancy     (out_occupancy),
    .out_is_empty      (out_is_empty)
  );

endmodule
